/* src/b2da_pkg.sv */
// Package for the binary to decimal ASCII unit.
// Holds the sequencer state type, the cell control struct and fixed constants.
// No dependencies.
package b2da_pkg;

  localparam int VALUE_W    = 64;
  localparam int BIT_CNT_W  = 6;
  localparam int DIGIT_W    = 4;
  localparam int CAP_W      = 5;
  localparam int TOTAL_W    = 5;
  localparam int CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_EMIT
  } state_t;

  // control shared by every digit cell
  typedef struct packed {
    logic clear;
    logic dabble;
    logic shift;
  } cell_ctrl_t;

endpackage

/* src/binary_to_decimal_ascii_unit.sv */
// Binary to decimal ASCII unit: top level, sequencer and output register.
// Instantiates a chain of b2da_cell digit cells; depends on b2da_pkg.
//
// Input channel (in_valid/in_ready): func, value, capacity. in_ready is high
// only while no conversion is in progress; one item is worked at a time.
// Output channel (out_valid/out_ready): one transfer per character, most
// significant first, '-' leading a negative signed value; last marks the
// final one and total_length is on every transfer. When the text would not
// fit capacity (or needs more than MAX_DIGITS digits) a single transfer with
// has_char 0, last 1 and total_length 0 is given instead.
// Sequence: after the input transfer the magnitude is shifted into the digit
// chain one bit a cycle, then leading zero digits are shifted out one a
// cycle, then one character per cycle, while the receiver accepts, leaves
// through the output register. Without receiver stalls the shift-in is the
// longest of these phases.
// A receiver stall holds the output register and pauses emission; nothing
// is dropped. Reset clears the sequencer and the output valid.
module binary_to_decimal_ascii_unit #(
  parameter int MAX_DIGITS = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             func,
  input  logic [b2da_pkg::VALUE_W-1:0]     value,
  input  logic [b2da_pkg::CAP_W-1:0]       capacity,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]      char_code,
  output logic                             has_char,
  output logic                             last,
  output logic [b2da_pkg::TOTAL_W-1:0]     total_length
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  b2da_pkg::state_t state, state_next;

  logic [b2da_pkg::VALUE_W-1:0]   mag;
  logic                           neg;
  logic [b2da_pkg::CAP_W-1:0]     cap;
  logic [b2da_pkg::BIT_CNT_W-1:0] bitcnt;
  logic                           ovf;
  logic [CNT_W-1:0]               shifts;
  logic                           fail;
  logic                           sign_pend;
  logic [b2da_pkg::TOTAL_W-1:0]   remain;
  logic [b2da_pkg::TOTAL_W-1:0]   total;

  b2da_pkg::cell_ctrl_t           cell_ctrl;
  logic [MAX_DIGITS-1:0]          bit_chain;
  logic [b2da_pkg::DIGIT_W-1:0]   digit_chain [MAX_DIGITS];
  logic [b2da_pkg::DIGIT_W-1:0]   top_digit;

  logic                           in_xfer;
  logic                           out_free;
  logic                           conv_done;
  logic                           norm_stop;
  logic [b2da_pkg::TOTAL_W-1:0]   ndig_calc;
  logic [b2da_pkg::TOTAL_W-1:0]   total_calc;
  logic                           emit_any;
  logic                           emit_ovf;
  logic                           emit_sign;
  logic                           emit_digit;

  // digit chain, cell 0 is the least significant digit
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    logic                         cin;
    logic [b2da_pkg::DIGIT_W-1:0] din;
    if (i == 0) begin : g_low
      assign cin = mag[b2da_pkg::VALUE_W-1];
      assign din = '0;
    end else begin : g_up
      assign cin = bit_chain[i-1];
      assign din = digit_chain[i-1];
    end
    b2da_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .bit_in    (cin),
      .digit_in  (din),
      .bit_out   (bit_chain[i]),
      .digit_out (digit_chain[i])
    );
  end

  assign top_digit  = digit_chain[MAX_DIGITS-1];
  assign in_xfer    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign conv_done  = (bitcnt == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_W - 1));
  assign norm_stop  = (top_digit != '0) || (shifts == CNT_W'(MAX_DIGITS - 1));
  assign ndig_calc  = b2da_pkg::TOTAL_W'(MAX_DIGITS) - b2da_pkg::TOTAL_W'(shifts);
  assign total_calc = ndig_calc + b2da_pkg::TOTAL_W'(neg);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      b2da_pkg::ST_IDLE: begin
        if (in_valid) state_next = b2da_pkg::ST_CONV;
      end
      b2da_pkg::ST_CONV: begin
        if (conv_done) state_next = b2da_pkg::ST_NORM;
      end
      b2da_pkg::ST_NORM: begin
        if (norm_stop) state_next = b2da_pkg::ST_EMIT;
      end
      b2da_pkg::ST_EMIT: begin
        if (out_free && (fail || (!sign_pend && remain == b2da_pkg::TOTAL_W'(1)))) begin
          state_next = b2da_pkg::ST_IDLE;
        end
      end
      default: state_next = b2da_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready         = 1'b0;
    emit_any         = 1'b0;
    cell_ctrl.clear  = 1'b0;
    cell_ctrl.dabble = 1'b0;
    cell_ctrl.shift  = 1'b0;
    case (state)
      b2da_pkg::ST_IDLE: begin
        // closed while reset is held so no transfer is taken and lost
        in_ready        = !rst;
        cell_ctrl.clear = in_valid;
      end
      b2da_pkg::ST_CONV: begin
        cell_ctrl.dabble = 1'b1;
      end
      b2da_pkg::ST_NORM: begin
        cell_ctrl.shift = !norm_stop;
      end
      b2da_pkg::ST_EMIT: begin
        emit_any        = out_free;
        cell_ctrl.shift = out_free && !fail && !sign_pend;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign emit_ovf   = emit_any && fail;
  assign emit_sign  = emit_any && !fail && sign_pend;
  assign emit_digit = emit_any && !fail && !sign_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b2da_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      neg    <= func && value[b2da_pkg::VALUE_W-1];
      mag    <= (func && value[b2da_pkg::VALUE_W-1]) ? (~value + 1'b1) : value;
      cap    <= capacity;
      bitcnt <= '0;
      ovf    <= 1'b0;
      shifts <= '0;
    end else if (state == b2da_pkg::ST_CONV) begin
      mag    <= {mag[b2da_pkg::VALUE_W-2:0], 1'b0};
      bitcnt <= bitcnt + 1'b1;
      // a bit leaving the top cell means more than MAX_DIGITS digits
      ovf    <= ovf || bit_chain[MAX_DIGITS-1];
    end else if (state == b2da_pkg::ST_NORM) begin
      if (norm_stop) begin
        total     <= total_calc;
        remain    <= ndig_calc;
        sign_pend <= neg;
        fail      <= ovf || (total_calc > cap);
      end else begin
        shifts <= shifts + 1'b1;
      end
    end else if (emit_sign) begin
      sign_pend <= 1'b0;
    end else if (emit_digit) begin
      remain <= remain - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ovf) begin
      char_code    <= '0;
      has_char     <= 1'b0;
      last         <= 1'b1;
      total_length <= '0;
    end else if (emit_sign) begin
      char_code    <= b2da_pkg::ASCII_MINUS;
      has_char     <= 1'b1;
      last         <= 1'b0;
      total_length <= total;
    end else if (emit_digit) begin
      char_code    <= b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(top_digit);
      has_char     <= 1'b1;
      last         <= (remain == b2da_pkg::TOTAL_W'(1));
      total_length <= total;
    end
  end

endmodule

/* src/b2da_cell.sv */
// One BCD digit cell of the conversion chain.
// Clear to zero, shift-add-3 step toward the upper neighbor, or a plain digit shift upward.
// Depends on b2da_pkg.
module b2da_cell (
  input  logic                           clk,
  input  b2da_pkg::cell_ctrl_t           ctrl,
  input  logic                           bit_in,
  input  logic [b2da_pkg::DIGIT_W-1:0]   digit_in,
  output logic                           bit_out,
  output logic [b2da_pkg::DIGIT_W-1:0]   digit_out
);

  logic [b2da_pkg::DIGIT_W-1:0] digit;
  logic [b2da_pkg::DIGIT_W-1:0] adj;

  always_comb begin
    if (digit >= b2da_pkg::DABBLE_MIN) begin
      adj = digit + b2da_pkg::DABBLE_ADD;
    end else begin
      adj = digit;
    end
  end

  assign bit_out   = adj[b2da_pkg::DIGIT_W-1];
  assign digit_out = digit;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {adj[b2da_pkg::DIGIT_W-2:0], bit_in};
    end else if (ctrl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

/* src/b2da_checker.sv */
// Port-level checks for binary_to_decimal_ascii_unit, plus the bind.
// Sees only the top-level ports; depends on b2da_pkg.
module b2da_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [b2da_pkg::CHAR_W-1:0]      char_code,
  input logic                             has_char,
  input logic                             last,
  input logic [b2da_pkg::TOTAL_W-1:0]     total_length
);

  // a new transfer starts a conversion, so the input closes
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an input transfer");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last)
      && $stable(total_length) && $stable(has_char))
    else $error("stalled output changed");

  // overflow result is a lone, empty, final transfer
  a_ovf_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> last && total_length == '0 && char_code == '0)
    else $error("malformed overflow result");

  // characters are digits or minus, with a nonzero length
  a_char_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_char |-> total_length != '0 && (char_code == b2da_pkg::ASCII_MINUS
      || (char_code >= b2da_pkg::ASCII_ZERO && char_code <= 8'h39)))
    else $error("bad character code");

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .char_code    (char_code),
  .has_char     (has_char),
  .last         (last),
  .total_length (total_length)
);
